// ===== hdl/pae_pkg.sv =====
package pae_pkg;

    // ring geometry
    localparam int RING_DEPTH = 8;
    localparam int IDX_W      = $clog2(RING_DEPTH);
    localparam int POS_W      = $clog2(RING_DEPTH + 1);
    localparam int MODN_W     = $clog2(RING_DEPTH + 2);
    localparam int SUM_W      = 8 + IDX_W;

    // field widths
    localparam int SPEED_W    = 16;
    localparam int INTERVAL_W = 16;
    localparam int CODE_W     = 8;
    localparam int WINDOW_W   = 8;
    localparam int HOLD_W     = 16;
    localparam int IN_DATA_W  = SPEED_W + INTERVAL_W;
    localparam int OUT_DATA_W = 2 * CODE_W;

    // shared divider
    localparam int NUM_W = 33;
    localparam int DEN_W = 25;
    localparam int CNT_W = $clog2(NUM_W + 1);

    // configuration port
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_WINDOW = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_HOLD   = 1'd1;

    // constants
    localparam logic [CODE_W-1:0]   NEUTRAL_CODE     = 8'd175;
    localparam logic [CODE_W-1:0]   CODE_MAX         = 8'd255;
    localparam logic [CODE_W-1:0]   RISE_LIMIT       = 8'd80;
    localparam logic [SPEED_W-1:0]  SMALL_DIFF_LIMIT = 16'd10995;
    localparam logic [18:0]         SPEED_SCALE      = 19'd390625;
    localparam logic [8:0]          INTERVAL_SCALE   = 9'd288;
    localparam logic [HOLD_W-1:0]   HOLD_MAX         = 16'hFFFF;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET     = 8'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_QDIV,
        ST_POSMOD,
        ST_UPDATE,
        ST_SUM,
        ST_MDIV,
        ST_DONE
    } state_t;

endpackage

// ===== hdl/pulse_accel_estimate_average.sv =====
// processing of an input word into a result word (ring depth 8): the 33-step
//   shift-subtract divider for the quotient dominates where it runs, then a short
//   modulo pass, one add per filled ring entry and an 11-step mean divide
// flow: one word at a time, input is not ready while a word is in work;
//   a finished result waits in the output register while the next word enters
// reset: asynchronous, active low; ring entries return to 175, counters to zero
module pulse_accel_estimate_average (
    input  logic                              clk,
    input  logic                              rst_n,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [pae_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // speed_now, pulse_interval
    input  logic                              s_axis_tuser,  // info_available
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [pae_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // accel_raw, accel_mean
    output logic                              m_axis_tuser,  // available_debounced
    // configuration writes
    input  logic                              cfg_we,
    input  logic [pae_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pae_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import pae_pkg::*;

    // control state
    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [POS_W-1:0]     idx_reg, idx_next;

    // configuration
    logic [WINDOW_W-1:0]  window_reg, window_next;
    logic [HOLD_W-1:0]    release_hold_reg, release_hold_next;

    // persistent block state
    logic [SPEED_W-1:0]   prev_speed_reg, prev_speed_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [POS_W-1:0]     fill_reg, fill_next;
    logic                 deb_reg, deb_next;
    logic [HOLD_W-1:0]    hold_reg, hold_next;
    logic [CODE_W-1:0]    ring_reg [RING_DEPTH];
    logic [CODE_W-1:0]    ring_next [RING_DEPTH];

    // word in work
    logic [SPEED_W-1:0]    speed_reg, speed_next;
    logic [INTERVAL_W-1:0] interval_reg, interval_next;
    logic                  avail_reg, avail_next;
    logic                  falling_reg, falling_next;
    logic [CODE_W-1:0]     raw_reg, raw_next;
    logic [CODE_W-1:0]     mean_reg, mean_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;

    // shared divider: quotient bits shift into num_reg from the bottom
    logic [NUM_W-1:0]     num_reg, num_next;
    logic [DEN_W-1:0]     den_reg, den_next;
    logic [DEN_W-1:0]     rem_reg, rem_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic [CODE_W-1:0]    out_raw_reg, out_raw_next;
    logic [CODE_W-1:0]    out_mean_reg, out_mean_next;
    logic                 out_deb_reg, out_deb_next;

    // datapath helpers
    logic [SPEED_W-1:0]   diff;
    logic                 falling;
    logic [DEN_W-1:0]     scaled_interval;
    logic [NUM_W-1:0]     scaled_diff;
    logic [DEN_W:0]       partial;
    logic [DEN_W:0]       partial_sub;
    logic                 div_ge;
    logic [DEN_W-1:0]     div_rem;
    logic [NUM_W-1:0]     div_num;
    logic [MODN_W-1:0]    pos_inc;
    logic [NUM_W-1:0]     mod_num;
    logic [CODE_W-1:0]    q_code;
    logic [POS_W-1:0]     upd_pos;
    logic [IDX_W-1:0]     upd_wpos;
    logic [WINDOW_W-1:0]  fill_inc;
    logic [WINDOW_W-1:0]  fill_win;
    logic [HOLD_W-1:0]    hold_inc;
    logic [HOLD_W-1:0]    hold_thd;
    logic                 upd_deb;
    logic [HOLD_W-1:0]    upd_hold;
    logic                 out_load;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_mean_reg, out_raw_reg};
    assign m_axis_tuser  = out_deb_reg;

    // speed change and scaled interval
    assign falling         = speed_reg < prev_speed_reg;
    assign diff            = falling ? (prev_speed_reg - speed_reg) : (speed_reg - prev_speed_reg);
    assign scaled_interval = DEN_W'(interval_reg) * DEN_W'(INTERVAL_SCALE);
    assign scaled_diff     = NUM_W'(diff[13:0]) * NUM_W'(SPEED_SCALE);

    // one restoring divide step
    assign partial     = {rem_reg, num_reg[NUM_W-1]};
    assign partial_sub = partial - {1'b0, den_reg};
    assign div_ge      = partial >= {1'b0, den_reg};
    assign div_rem     = div_ge ? partial_sub[DEN_W-1:0] : partial[DEN_W-1:0];
    assign div_num     = {num_reg[NUM_W-2:0], div_ge};

    // next write position is (position + 1) mod window, done on the divider
    assign pos_inc = MODN_W'(pos_reg) + MODN_W'(1);
    assign mod_num = NUM_W'(pos_inc) << (NUM_W - MODN_W);

    // clamp the quotient around the neutral code
    always_comb
    begin
        if (!falling_reg)
        begin
            q_code = (num_reg >= NUM_W'(RISE_LIMIT)) ? CODE_MAX
                                                     : NEUTRAL_CODE + num_reg[CODE_W-1:0];
        end
        else
        begin
            q_code = (num_reg >= NUM_W'(NEUTRAL_CODE)) ? '0
                                                       : NEUTRAL_CODE - num_reg[CODE_W-1:0];
        end
    end

    // ring position, fill count and debounce for the update step
    always_comb
    begin
        if (window_reg == '0 || rem_reg >= DEN_W'(RING_DEPTH))
        begin
            upd_pos = POS_W'(RING_DEPTH);
        end
        else
        begin
            upd_pos = rem_reg[POS_W-1:0];
        end

        if (window_reg == '0 || rem_reg >= DEN_W'(RING_DEPTH - 1))
        begin
            upd_wpos = IDX_W'(RING_DEPTH - 1);
        end
        else
        begin
            upd_wpos = rem_reg[IDX_W-1:0];
        end

        fill_inc = WINDOW_W'(fill_reg) + WINDOW_W'(1);
        fill_win = (fill_inc > window_reg) ? window_reg : fill_inc;
        if (fill_win > WINDOW_W'(RING_DEPTH))
        begin
            fill_win = WINDOW_W'(RING_DEPTH);
        end

        // falling edge of the flag waits for the hold count, rising is immediate
        hold_inc = (hold_reg != HOLD_MAX) ? hold_reg + HOLD_W'(1) : hold_reg;
        hold_thd = avail_reg ? '0 : release_hold_reg;
        upd_deb  = deb_reg;
        upd_hold = '0;
        if (avail_reg != deb_reg)
        begin
            if (hold_inc >= hold_thd)
            begin
                upd_deb  = avail_reg;
                upd_hold = '0;
            end
            else
            begin
                upd_hold = hold_inc;
            end
        end
    end

    assign out_load = !out_valid_reg || m_axis_tready;

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        idx_next          = idx_reg;
        window_next       = window_reg;
        release_hold_next = release_hold_reg;
        prev_speed_next   = prev_speed_reg;
        pos_next          = pos_reg;
        fill_next         = fill_reg;
        deb_next          = deb_reg;
        hold_next         = hold_reg;
        ring_next         = ring_reg;
        speed_next        = speed_reg;
        interval_next     = interval_reg;
        avail_next        = avail_reg;
        falling_next      = falling_reg;
        raw_next          = raw_reg;
        mean_next         = mean_reg;
        sum_next          = sum_reg;
        num_next          = num_reg;
        den_next          = den_reg;
        rem_next          = rem_reg;
        out_valid_next    = out_valid_reg;
        out_raw_next      = out_raw_reg;
        out_mean_next     = out_mean_reg;
        out_deb_next      = out_deb_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_AVERAGE_WINDOW: window_next       = cfg_data[WINDOW_W-1:0];
                CFG_RELEASE_HOLD:   release_hold_next = cfg_data[HOLD_W-1:0];
                default:            window_next       = window_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    speed_next    = s_axis_tdata[SPEED_W-1:0];
                    interval_next = s_axis_tdata[IN_DATA_W-1:SPEED_W];
                    avail_next    = s_axis_tuser;
                    state_next    = ST_PREP;
                end
            end

            ST_PREP:
            begin
                falling_next = falling;
                if (diff == '0)
                begin
                    raw_next = NEUTRAL_CODE;
                end
                else
                begin
                    raw_next = falling ? '0 : CODE_MAX;
                end
                // no interval, no change or a large change: code is fixed
                if (interval_reg == '0 || diff == '0 || diff > SMALL_DIFF_LIMIT)
                begin
                    num_next   = mod_num;
                    den_next   = DEN_W'(window_reg);
                    rem_next   = '0;
                    cnt_next   = CNT_W'(MODN_W);
                    state_next = ST_POSMOD;
                end
                else
                begin
                    // rounded quotient: (d * 390625 + t / 2) / t
                    num_next   = scaled_diff + NUM_W'(scaled_interval >> 1);
                    den_next   = scaled_interval;
                    rem_next   = '0;
                    cnt_next   = CNT_W'(NUM_W);
                    state_next = ST_QDIV;
                end
            end

            ST_QDIV:
            begin
                if (cnt_reg != '0)
                begin
                    num_next = div_num;
                    rem_next = div_rem;
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                else
                begin
                    raw_next   = q_code;
                    num_next   = mod_num;
                    den_next   = DEN_W'(window_reg);
                    rem_next   = '0;
                    cnt_next   = CNT_W'(MODN_W);
                    state_next = ST_POSMOD;
                end
            end

            ST_POSMOD:
            begin
                if (cnt_reg != '0)
                begin
                    num_next = div_num;
                    rem_next = div_rem;
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                else
                begin
                    state_next = ST_UPDATE;
                end
            end

            ST_UPDATE:
            begin
                pos_next            = upd_pos;
                fill_next           = fill_win[POS_W-1:0];
                deb_next            = upd_deb;
                hold_next           = upd_hold;
                ring_next[upd_wpos] = upd_deb ? raw_reg : NEUTRAL_CODE;
                prev_speed_next     = speed_reg;
                sum_next            = '0;
                idx_next            = '0;
                state_next          = ST_SUM;
            end

            ST_SUM:
            begin
                if (idx_reg == fill_reg)
                begin
                    if (fill_reg == '0)
                    begin
                        mean_next  = NEUTRAL_CODE;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        num_next   = NUM_W'(sum_reg) << (NUM_W - SUM_W);
                        den_next   = DEN_W'(fill_reg);
                        rem_next   = '0;
                        cnt_next   = CNT_W'(SUM_W);
                        state_next = ST_MDIV;
                    end
                end
                else
                begin
                    sum_next = sum_reg + SUM_W'(ring_reg[idx_reg[IDX_W-1:0]]);
                    idx_next = idx_reg + POS_W'(1);
                end
            end

            ST_MDIV:
            begin
                if (cnt_reg != '0)
                begin
                    num_next = div_num;
                    rem_next = div_rem;
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                else
                begin
                    mean_next  = num_reg[CODE_W-1:0];
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_raw_next   = raw_reg;
                    out_mean_next  = mean_reg;
                    out_deb_next   = deb_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            idx_reg          <= '0;
            window_reg       <= WINDOW_RESET;
            release_hold_reg <= '0;
            prev_speed_reg   <= '0;
            pos_reg          <= '0;
            fill_reg         <= '0;
            deb_reg          <= 1'b0;
            hold_reg         <= '0;
            out_valid_reg    <= 1'b0;
            for (int i = 0; i < RING_DEPTH; i++)
            begin
                ring_reg[i] <= NEUTRAL_CODE;
            end
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            idx_reg          <= idx_next;
            window_reg       <= window_next;
            release_hold_reg <= release_hold_next;
            prev_speed_reg   <= prev_speed_next;
            pos_reg          <= pos_next;
            fill_reg         <= fill_next;
            deb_reg          <= deb_next;
            hold_reg         <= hold_next;
            out_valid_reg    <= out_valid_next;
            ring_reg         <= ring_next;
        end
    end

    // working data, no reset needed
    always_ff @(posedge clk)
    begin
        speed_reg    <= speed_next;
        interval_reg <= interval_next;
        avail_reg    <= avail_next;
        falling_reg  <= falling_next;
        raw_reg      <= raw_next;
        mean_reg     <= mean_next;
        sum_reg      <= sum_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        out_raw_reg  <= out_raw_next;
        out_mean_reg <= out_mean_next;
        out_deb_reg  <= out_deb_next;
    end

endmodule

// ===== dv/tb.sv =====
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import pae_pkg::*;

    // acceleration code one step above the neutral code at the 1/5 scale
    localparam logic [31:0] SPEED_SCALE_FIFTH = 32'd78125;
    // quiet cycles after the last result before a register write or the end
    localparam int SETTLE_CYCLES = 80;
    // length of the long receiver hold-off
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_WORDS = 50;

    // one result word as the block should produce it
    typedef struct packed {
        logic [CODE_W-1:0] raw;
        logic [CODE_W-1:0] mean;
        logic              avail;
    } accel_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // speed_now, pulse_interval
    logic                  s_axis_tuser = 1'b0; // info_available
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // accel_raw, accel_mean
    logic                  m_axis_tuser;        // available_debounced
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_AVERAGE_WINDOW;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // expected accel results, oldest first
    accel_result_t accel_expected[$];
    int            fail_count = 0;

    // idling switches for the two sides, and the long hold-off request
    logic tx_idle_on = 1'b1;
    logic rx_idle_on = 1'b1;
    logic long_hold_req = 1'b0;

    // shadow of the block's registers and state
    logic [WINDOW_W-1:0] window_setting;
    logic [HOLD_W-1:0]   release_setting;
    logic [SPEED_W-1:0]  last_speed;
    int                  ring_pos;
    int                  fill_cnt;
    logic                avail_db;
    int                  hold_cnt;
    logic [CODE_W-1:0]   accel_hist [RING_DEPTH];

    pulse_accel_estimate_average u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // run limit, far above the slowest legal run
    initial
    begin
        #5_000_000;
        $display("pulse_accel_estimate_average verification failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        fail_count++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // instant acceleration code from a speed change over one pulse interval
    function automatic logic [CODE_W-1:0] accel_code_of(input logic [SPEED_W-1:0] now_spd,
                                                        input logic [SPEED_W-1:0] prev_spd,
                                                        input logic [INTERVAL_W-1:0] interval);
        logic [63:0] t;
        logic [63:0] d;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] f;
        logic        falling;
        t = 64'(interval) * 64'(INTERVAL_SCALE);
        falling = now_spd < prev_spd;
        d = falling ? 64'(prev_spd - now_spd) : 64'(now_spd - prev_spd);
        // zero interval: full scale one way or the other, neutral if no change
        if (t == 0)
            return (d == 0) ? NEUTRAL_CODE : (falling ? '0 : CODE_MAX);
        if (d <= 64'(SMALL_DIFF_LIMIT))
        begin
            // rounded quotient, exact in 64 bits
            q = (d * 64'(SPEED_SCALE) + t / 2) / t;
        end
        else
        begin
            // whole part plus a fraction from the remainder
            r = d % t;
            q = (d / t) * 64'(SPEED_SCALE);
            if (r <= 64'(SMALL_DIFF_LIMIT))
                f = r * 64'(SPEED_SCALE) / t;
            else
                f = ((r + t / 2) * 5 / t) * 64'(SPEED_SCALE_FIFTH);
            q += f;
        end
        if (falling)
            return (q >= 64'(NEUTRAL_CODE)) ? '0 : CODE_W'(64'(NEUTRAL_CODE) - q);
        return (q >= 64'(RISE_LIMIT)) ? CODE_MAX : CODE_W'(64'(NEUTRAL_CODE) + q);
    endfunction

    // advance the shadow state by one pulse and queue the expected word
    task automatic predict_pulse(input logic [SPEED_W-1:0] speed,
                                 input logic [INTERVAL_W-1:0] interval,
                                 input logic avail);
        accel_result_t res;
        int            nxt;
        int            wpos;
        int            thd;
        int            sum;
        res.raw = accel_code_of(speed, last_speed, interval);

        // write position: a zero window parks on the last entry
        if (window_setting == 0)
            nxt = RING_DEPTH;
        else
            nxt = (ring_pos + 1) % int'(window_setting);
        ring_pos = (nxt < RING_DEPTH) ? nxt : RING_DEPTH;
        wpos = (nxt < RING_DEPTH - 1) ? nxt : RING_DEPTH - 1;

        // filled entries, limited by window and ring depth
        fill_cnt = fill_cnt + 1;
        if (fill_cnt > int'(window_setting))
            fill_cnt = int'(window_setting);
        if (fill_cnt > RING_DEPTH)
            fill_cnt = RING_DEPTH;

        // debounce: rising at once, falling after the hold count
        if (avail != avail_db)
        begin
            thd = avail ? 0 : int'(release_setting);
            if (hold_cnt < int'(HOLD_MAX))
                hold_cnt++;
            if (hold_cnt >= thd)
            begin
                avail_db = avail;
                hold_cnt = 0;
            end
        end
        else
        begin
            hold_cnt = 0;
        end

        accel_hist[wpos] = avail_db ? res.raw : NEUTRAL_CODE;

        sum = 0;
        for (int i = 0; i < fill_cnt; i++)
            sum += int'(accel_hist[i]);
        res.mean = (fill_cnt != 0) ? CODE_W'(sum / fill_cnt) : NEUTRAL_CODE;
        res.avail = avail_db;

        last_speed = speed;
        accel_expected.push_back(res);
    endtask

    // offer one pulse word; valid stays high so back-to-back words need no gap
    task automatic send_pulse(input logic [SPEED_W-1:0] speed,
                              input logic [INTERVAL_W-1:0] interval,
                              input logic avail);
        int gap;
        gap = tx_idle_on ? int'($urandom_range(0, 17)) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {interval, speed};
        s_axis_tuser <= avail;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_pulse(speed, interval, avail);
    endtask

    // stop offering, wait for every expected word, then let the block settle
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (accel_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write, only while the block is idle
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_AVERAGE_WINDOW)
            window_setting = value[WINDOW_W-1:0];
        else
            release_setting = value[HOLD_W-1:0];
    endtask

    // window write with junk in the unused upper bits
    task automatic set_window(input int win);
        write_register(CFG_AVERAGE_WINDOW,
                       {8'($urandom_range(0, 255)), WINDOW_W'(win)});
    endtask

    // result side: random stalls, one long hold-off on request, field checks
    initial
    begin : result_sink
        int            gap;
        accel_result_t want;
        forever
        begin
            if (long_hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold_req = 1'b0;
            end
            else
            begin
                gap = rx_idle_on ? int'($urandom_range(0, 17)) : 0;
                if (gap > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            if (accel_expected.size() == 0)
            begin
                report_mismatch("unexpected word, accel_raw", m_axis_tdata[7:0], -1);
            end
            else
            begin
                want = accel_expected.pop_front();
                if (m_axis_tdata[7:0] != want.raw)
                    report_mismatch("accel_raw", m_axis_tdata[7:0], want.raw);
                if (m_axis_tdata[15:8] != want.mean)
                    report_mismatch("accel_mean", m_axis_tdata[15:8], want.mean);
                if (m_axis_tuser != want.avail)
                    report_mismatch("available_debounced", m_axis_tuser, want.avail);
            end
        end
    end

    // zero intervals, both quotient forms and their boundaries, clamping
    task automatic test_codes_directed();
        send_pulse(16'd0, 16'd0, 1'b0);          // no change, zero interval
        send_pulse(16'd65535, 16'd0, 1'b1);      // rising, zero interval
        send_pulse(16'd0, 16'd0, 1'b1);          // falling, zero interval
        send_pulse(16'd0, 16'd65535, 1'b1);      // no change
        send_pulse(16'd100, 16'd65535, 1'b1);    // small rise
        send_pulse(16'd0, 16'd65535, 1'b1);      // small fall
        send_pulse(16'd20000, 16'd1, 1'b1);      // large change, small remainder
        send_pulse(16'd42520, 16'd40, 1'b1);     // large change, large remainder
        send_pulse(16'd31000, 16'd65535, 1'b1);  // large fall below one interval
        send_pulse(16'd41995, 16'd65535, 1'b1);  // change right at the small limit
        send_pulse(16'd52991, 16'd65535, 1'b1);  // one past the small limit
        send_pulse(16'd52991, 16'd1000, 1'b0);   // availability drops at once
        send_pulse(16'd52990, 16'd65535, 1'b0);  // rounds to neutral
        send_pulse(16'd52900, 16'd20000, 1'b1);
        send_pulse(16'd53000, 16'd30000, 1'b1);
        send_pulse(16'd65535, 16'd65535, 1'b1);
        send_pulse(16'd65500, 16'd65535, 1'b1);
        send_pulse(16'd65535, 16'd1, 1'b0);
        send_pulse(16'd0, 16'd1, 1'b1);          // full-scale fall
        drain_results();
    endtask

    // falling edge of the availability flag waits out the hold count
    task automatic test_release_hold();
        write_register(CFG_RELEASE_HOLD, 16'd3);
        send_pulse(16'd1000, 16'd5000, 1'b1);
        send_pulse(16'd1010, 16'd5000, 1'b1);
        send_pulse(16'd1020, 16'd5000, 1'b0);
        send_pulse(16'd1030, 16'd5000, 1'b0);
        send_pulse(16'd1040, 16'd5000, 1'b1);    // glitch back clears the count
        send_pulse(16'd1050, 16'd5000, 1'b0);
        send_pulse(16'd1060, 16'd5000, 1'b0);
        send_pulse(16'd1070, 16'd5000, 1'b0);    // third in a row: flag falls
        send_pulse(16'd1060, 16'd5000, 1'b0);
        send_pulse(16'd1050, 16'd5000, 1'b1);    // rises at once
        drain_results();
        write_register(CFG_RELEASE_HOLD, 16'hFFFF);
        send_pulse(16'd1040, 16'd4000, 1'b1);
        repeat (5)
            send_pulse(16'(last_speed + 16'd7), 16'd4000, 1'b0);
        drain_results();
        write_register(CFG_RELEASE_HOLD, 16'd0);
    endtask

    // realistic pulse: small speed step over a moderate interval
    task automatic send_smooth_pulse(input logic avail);
        int s;
        s = int'(last_speed) + int'($urandom_range(0, 300)) - 150;
        if (s < 0)
            s = 0;
        if (s > 65535)
            s = 65535;
        send_pulse(16'(s), 16'($urandom_range(200, 65535)), avail);
    endtask

    // ring modulus from zero up to full scale
    task automatic test_window_settings();
        int wins[8] = '{0, 1, 2, 5, 7, 8, 9, 255};
        foreach (wins[k])
        begin
            set_window(wins[k]);
            repeat (12)
                send_smooth_pulse($urandom_range(0, 7) != 0);
            drain_results();
        end
        set_window(8);
    endtask

    // receiver holds off while the sender keeps offering back to back
    task automatic test_output_backpressure();
        tx_idle_on = 1'b0;
        long_hold_req = 1'b1;
        repeat (12)
            send_smooth_pulse(1'b1);
        drain_results();
        tx_idle_on = 1'b1;
    endtask

    // phases of mixed traffic with a fresh register setting each
    task automatic test_random_traffic();
        int mode;
        int s;
        int delta;
        int win;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case ($urandom_range(0, 3))
                0: win = $urandom_range(0, 10);
                1: win = $urandom_range(0, 255);
                default: win = $urandom_range(1, 9);
            endcase
            set_window(win);
            if ($urandom_range(0, 3) == 0)
                write_register(CFG_RELEASE_HOLD, 16'($urandom_range(0, 65535)));
            else
                write_register(CFG_RELEASE_HOLD, 16'($urandom_range(0, 6)));
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                mode = $urandom_range(0, 9);
                if (mode <= 5)
                begin
                    send_smooth_pulse($urandom_range(0, 9) != 0);
                end
                else if (mode <= 7)
                begin
                    // anything the fields allow
                    send_pulse(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                               1'($urandom_range(0, 1)));
                end
                else if (mode == 8)
                begin
                    // zero interval, sometimes with no change
                    s = ($urandom_range(0, 3) == 0) ? int'(last_speed)
                                                     : int'($urandom_range(0, 65535));
                    send_pulse(16'(s), 16'd0, 1'($urandom_range(0, 1)));
                end
                else
                begin
                    // change around the small-difference limit
                    delta = 10990 + int'($urandom_range(0, 10));
                    if ($urandom_range(0, 1) != 0)
                        s = int'(last_speed) + delta;
                    else
                        s = int'(last_speed) - delta;
                    if (s > 65535)
                        s = int'(last_speed) - delta;
                    if (s < 0)
                        s = int'(last_speed) + delta;
                    send_pulse(16'(s), 16'($urandom_range(1, 65535)), 1'b1);
                end
            end
            drain_results();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial
    begin
        // shadow state as after reset
        window_setting = WINDOW_RESET;
        release_setting = '0;
        last_speed = '0;
        ring_pos = 0;
        fill_cnt = 0;
        avail_db = 1'b0;
        hold_cnt = 0;
        foreach (accel_hist[i])
            accel_hist[i] = NEUTRAL_CODE;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_codes_directed();
        test_release_hold();
        test_window_settings();
        test_output_backpressure();
        test_random_traffic();

        drain_results();
        if (accel_expected.size() != 0)
            report_mismatch("words never delivered", 0, accel_expected.size());
        if (fail_count == 0)
            $display("pulse_accel_estimate_average verification clean");
        else
            $display("pulse_accel_estimate_average verification failed");
        $finish;
    end

endmodule
